// ----- rtl/vfc_pkg.sv -----
// vfc_pkg: shared widths, operation codes and helpers for the frustum cull block
// no dependencies
package vfc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int VW          = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CW          = VW + 1;   // plane coefficient
  localparam int PW          = CW + VW;  // coefficient times value
  localparam int SW          = PW + 3;   // dot product plus radius term
  localparam int LW          = CW + 2;   // sum of three magnitudes
  localparam int NPLANE      = 6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_SPHERE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  function automatic logic signed [VW-1:0] narrow(input logic [31:0] raw);
    narrow = raw[VW-1:0];
  endfunction

endpackage

// ----- rtl/vfc_plane.sv -----
// vfc_plane: one clip plane test, four register stages (coefficients, products, sum, decide)
// depends on vfc_pkg
module vfc_plane
  import vfc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  // column k entries of rows 1..4, then column 4 entries of rows 1..4
  input  logic signed [VW-1:0] m_a_i, m_b_i, m_c_i, m_d_i,
  input  logic signed [VW-1:0] w_a_i, w_b_i, w_c_i, w_d_i,
  input  logic                 col_sub_i,
  input  logic                 sphere_i,
  input  logic signed [VW-1:0] x_i, y_i, z_i, w_i,
  output logic                 pass_o
);

  // stage 1: coefficients, point and radius magnitude
  logic signed [CW-1:0] a_q, b_q, c_q, d_q;
  logic signed [VW-1:0] x_q, y_q, z_q;
  logic        [VW-1:0] r_q;
  logic                 sph1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (col_sub_i) begin
        a_q <= CW'(w_a_i) - CW'(m_a_i);
        b_q <= CW'(w_b_i) - CW'(m_b_i);
        c_q <= CW'(w_c_i) - CW'(m_c_i);
        d_q <= CW'(w_d_i) - CW'(m_d_i);
      end else begin
        a_q <= CW'(w_a_i) + CW'(m_a_i);
        b_q <= CW'(w_b_i) + CW'(m_b_i);
        c_q <= CW'(w_c_i) + CW'(m_c_i);
        d_q <= CW'(w_d_i) + CW'(m_d_i);
      end
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_i;
      r_q    <= w_i[VW-1] ? VW'(-w_i) : w_i;
      sph1_q <= sphere_i;
    end
  end

  // stage 2: products and magnitude sum
  logic signed [PW-1:0] px_q, py_q, pz_q, pd_q;
  logic        [LW-1:0] l1_q;
  logic        [VW-1:0] r2_q;
  logic                 sph2_q;
  logic        [CW-1:0] ma, mb, mc;

  always_comb begin
    ma = a_q[CW-1] ? CW'(-a_q) : a_q;
    mb = b_q[CW-1] ? CW'(-b_q) : b_q;
    mc = c_q[CW-1] ? CW'(-c_q) : c_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= PW'(a_q) * PW'(x_q);
      py_q   <= PW'(b_q) * PW'(y_q);
      pz_q   <= PW'(c_q) * PW'(z_q);
      pd_q   <= PW'(d_q) <<< 16;
      l1_q   <= LW'(ma) + LW'(mb) + LW'(mc);
      r2_q   <= r_q;
      sph2_q <= sph1_q;
    end
  end

  // stage 3: dot sum and radius product
  logic signed [SW-1:0] dot_q;
  logic        [SW-1:0] rad_q;
  logic                 sph3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q  <= SW'(px_q) + SW'(py_q) + SW'(pz_q) + SW'(pd_q);
      rad_q  <= SW'(r2_q) * SW'(l1_q);
      sph3_q <= sph2_q;
    end
  end

  // stage 4: sign decision
  logic signed [SW:0] tot;
  assign tot = (SW+1)'(dot_q) + (SW+1)'($signed({1'b0, rad_q}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sph3_q) pass_o <= !tot[SW] && (tot != '0);
      else        pass_o <= !dot_q[SW-1];
    end
  end

endmodule

// ----- rtl/view_frustum_cull_top.sv -----
// view_frustum_cull_top: matrix store, six plane pipelines and result stage
// depends on vfc_pkg and vfc_plane
//
//  channel  signals                                         dir
//  in       in_valid_i in_stall_o operation_i row_index_i    in
//           x_i y_i z_i w_i
//  out      out_valid_o out_stall_i inside_res_o             out
//
// results leave through the output register; one beat each cycle unless stalled
// all six planes run side by side, four stages each plus the output register
// the whole pipe advances together when the output register is free
// reset clears the matrix and every valid bit
module view_frustum_cull_top
  import vfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  row_index_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] z_i,
  input  logic [31:0] w_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        inside_res_o
);

  logic signed [VW-1:0] m_q [4][4];
  logic [3:0] vld_q;   // stages 1..4
  logic       adv;
  logic       is_test;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign is_test    = (operation_i == OP_POINT) || (operation_i == OP_SPHERE);

  logic signed [VW-1:0] xn, yn, zn, wn;
  assign xn = narrow(x_i);
  assign yn = narrow(y_i);
  assign zn = narrow(z_i);
  assign wn = narrow(w_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) m_q[r][c] <= '0;
    end else if (in_valid_i && adv && operation_i == OP_LOAD) begin
      m_q[row_index_i][0] <= xn;
      m_q[row_index_i][1] <= yn;
      m_q[row_index_i][2] <= zn;
      m_q[row_index_i][3] <= wn;
    end
  end

  logic [NPLANE-1:0] pass;

  for (genvar p = 0; p < NPLANE; p++) begin : g_plane
    vfc_plane u_plane (
      .clk_i     (clk_i),
      .en_i      (adv),
      .m_a_i     (m_q[0][p/2]),
      .m_b_i     (m_q[1][p/2]),
      .m_c_i     (m_q[2][p/2]),
      .m_d_i     (m_q[3][p/2]),
      .w_a_i     (m_q[0][3]),
      .w_b_i     (m_q[1][3]),
      .w_c_i     (m_q[2][3]),
      .w_d_i     (m_q[3][3]),
      .col_sub_i (1'(p % 2)),
      .sphere_i  (operation_i == OP_SPHERE),
      .x_i       (xn),
      .y_i       (yn),
      .z_i       (zn),
      .w_i       (wn),
      .pass_o    (pass[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[2:0], in_valid_i && is_test};
      out_valid_o <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) inside_res_o <= &pass;
  end

endmodule
